>>> src/lhntg_pkg.sv
// Shared types, widths and helpers for the lattice hop neighbor table generator.
// No dependencies; imported by the top level.

package lhntg_pkg;

    localparam int NUM_DIMS   = 4;
    localparam int EXT_W      = 7;
    localparam int COORD_W    = 6;
    localparam int IDX_W      = 24;
    localparam int VOL_W      = 25;
    localparam int PROD_W     = 13;
    localparam int CROSS_W    = 19;
    localparam int NL_W       = 21;
    localparam int CNT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_EXTENT = 64;
    localparam int EXT_MIN    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENT_X   = 3'd0,
        REG_EXTENT_Y   = 3'd1,
        REG_EXTENT_Z   = 3'd2,
        REG_EXTENT_T   = 3'd3,
        REG_ORDER_MODE = 3'd4
    } cfg_reg_t;

    typedef logic [EXT_W-1:0]   ext_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [VOL_W-1:0]   vol_t;
    typedef logic [CROSS_W-1:0] cross_t;

    function automatic ext_t clamp_extent(input ext_t e);
        ext_t r;
        if (e < EXT_W'(EXT_MIN))
            r = EXT_W'(EXT_MIN);
        else if (e > EXT_W'(MAX_EXTENT))
            r = EXT_W'(MAX_EXTENT);
        else
            r = e;
        return r;
    endfunction

    // checkerboard: even-parity sites land in the upper half
    function automatic idx_t order_index(input idx_t lex, input logic par,
                                         input vol_t vol, input logic mode);
        idx_t r;
        if (!mode)
            r = lex;
        else if (!par)
            r = (lex >> 1) + IDX_W'(vol >> 1);
        else
            r = lex >> 1;
        return r;
    endfunction

endpackage

>>> src/lattice_hop_neighbor_table_gen_top.sv
// Neighbor table entry generator for a 4D periodic sub-lattice with halo.
// Uses lhntg_pkg and two lhntg_ram instances for the slot counters.
//
// Usage:
//   Configuration: cfg_we/cfg_index/cfg_data write the four extents (index 0..3)
//   and the order mode (index 4); other indexes are ignored. After a write the
//   input stays stalled while the volume and stride products settle.
//   Input stream s_axis_*: one transfer per site/axis/hop request. tdata holds
//   coord_x, coord_y, coord_z, coord_t, axis, hop_len, clear from bit 0 up.
//   Output stream m_axis_*: two transfers per request, negative direction first,
//   tlast marks the second. tuser carries direction and is_halo.
//   Sequencing: one request is in flight at a time. A request passes through the
//   states S_MUL, S_SUM, S_IDX and S_ORD, then S_OUT0 and S_OUT1 load the two
//   results in turn; the steps are set by the multiply stages and the slot counter
//   read-modify-write through the counter memories with registered read data.
//   Output stalls: the result register holds until taken and the sequencer waits,
//   so no entry is lost; the input is not ready meanwhile.
//   Reset: extents return to 4, order mode to lexicographic, all counters read
//   as zero (per-entry valid bits), both streams go idle and the input stays stalled until settled.
//   A request with clear set zeroes all counters before it is processed.

module lattice_hop_neighbor_table_gen_top
    import lhntg_pkg::*;
#(
    parameter int MAX_HOP_LEN = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EXT_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // coord_x[5:0], coord_y[11:6], coord_z[17:12], coord_t[23:18], axis[25:24],
    // hop_len[27:26], clear[28], zero fill
    input  logic [31:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // slot[23:0], src_index[47:24], dest_index[71:48], overflow[72], zero fill
    output logic [79:0]          m_axis_tdata,
    // direction[2:0], is_halo[3]
    output logic [3:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int CNT_DEPTH = MAX_HOP_LEN * 2 * NUM_DIMS;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_IDX,
        S_ORD,
        S_OUT0,
        S_OUT1
    } state_t;

    // configuration and derived lattice geometry
    ext_t   ext_cfg_reg [NUM_DIMS];
    logic   order_mode_reg;
    ext_t   ext_reg [NUM_DIMS];
    logic [PROD_W-1:0] p01_reg;
    logic [PROD_W-1:0] p23_reg;
    vol_t   vol_reg;
    cross_t cross_reg [NUM_DIMS];
    logic [1:0] settle_reg;

    // sequencer and result register
    state_t state_reg;
    logic   out_valid_reg;
    logic [79:0] out_data_reg;
    logic [3:0]  out_user_reg;
    logic        out_last_reg;
    logic [CNT_DEPTH-1:0] lvalid_reg;
    logic [CNT_DEPTH-1:0] hvalid_reg;

    // item payload
    coord_t c_reg [NUM_DIMS];
    logic [1:0] axis_reg;
    logic [1:0] hop_reg;
    idx_t   term_reg [NUM_DIMS];
    logic   halo_reg [2];
    coord_t nei_reg [2];
    logic [NL_W-1:0] nl_reg;
    vol_t   l_reg;
    idx_t   base_reg;
    idx_t   m_reg [2];
    logic [CNT_W-1:0] slot_reg [2];
    logic   ovf_reg [2];
    idx_t   lex_reg;
    idx_t   lexn_reg [2];
    idx_t   self_reg;
    idx_t   dest_reg [2];

    // input decode
    coord_t in_coord [NUM_DIMS];
    logic [1:0] in_axis;
    logic [1:0] in_hop;
    logic       in_clear;
    logic [1:0] hop_next;
    logic       accept;
    logic       out_free;

    assign in_coord[0] = s_axis_tdata[5:0];
    assign in_coord[1] = s_axis_tdata[11:6];
    assign in_coord[2] = s_axis_tdata[17:12];
    assign in_coord[3] = s_axis_tdata[23:18];
    assign in_axis     = s_axis_tdata[25:24];
    assign in_hop      = s_axis_tdata[27:26];
    assign in_clear    = s_axis_tdata[28];

    assign s_axis_tready = (state_reg == S_IDLE) && (settle_reg == 2'd0);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (in_hop == 2'd0)
            hop_next = 2'd1;
        else if (in_hop > 2'(MAX_HOP_LEN))
            hop_next = 2'(MAX_HOP_LEN);
        else
            hop_next = in_hop;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                ext_cfg_reg[i] <= EXT_W'(EXT_MIN);
            end
            order_mode_reg <= 1'b0;
            settle_reg     <= 2'd2;
        end
        else
        begin
            if (cfg_we)
            begin
                settle_reg <= 2'd2;
                unique case (cfg_reg_t'(cfg_index))
                    REG_EXTENT_X:   ext_cfg_reg[0] <= cfg_data;
                    REG_EXTENT_Y:   ext_cfg_reg[1] <= cfg_data;
                    REG_EXTENT_Z:   ext_cfg_reg[2] <= cfg_data;
                    REG_EXTENT_T:   ext_cfg_reg[3] <= cfg_data;
                    REG_ORDER_MODE: order_mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // geometry products, registered behind the configuration in ext_reg, p01_reg/p23_reg, then vol_reg and cross_reg
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            ext_reg[i] <= clamp_extent(ext_cfg_reg[i]);
        end
        p01_reg <= PROD_W'(PROD_W'(ext_reg[0]) * PROD_W'(ext_reg[1]));
        p23_reg <= PROD_W'(PROD_W'(ext_reg[2]) * PROD_W'(ext_reg[3]));
        vol_reg <= VOL_W'(VOL_W'(p01_reg) * VOL_W'(p23_reg));
        cross_reg[0] <= CROSS_W'(CROSS_W'(ext_reg[1]) * CROSS_W'(p23_reg));
        cross_reg[1] <= CROSS_W'(CROSS_W'(ext_reg[0]) * CROSS_W'(p23_reg));
        cross_reg[2] <= CROSS_W'(CROSS_W'(p01_reg) * CROSS_W'(ext_reg[3]));
        cross_reg[3] <= CROSS_W'(CROSS_W'(p01_reg) * CROSS_W'(ext_reg[2]));
    end

    // hop neighbors, halo flags and table limits
    coord_t ca;
    ext_t   size;
    ext_t   hop_e;
    ext_t   ca_e;
    logic   halo_c [2];
    coord_t nei_c [2];
    cross_t cross_sel;
    logic [NL_W-1:0] nl_c;
    idx_t   term_c [NUM_DIMS];

    always_comb
    begin
        ca        = c_reg[axis_reg];
        size      = ext_reg[axis_reg];
        hop_e     = EXT_W'(hop_reg);
        ca_e      = EXT_W'(ca);
        halo_c[0] = ca_e < hop_e;
        nei_c[0]  = halo_c[0] ? COORD_W'(size - hop_e + ca_e) : COORD_W'(ca_e - hop_e);
        halo_c[1] = ca_e >= (size - hop_e);
        nei_c[1]  = halo_c[1] ? COORD_W'(ca_e + hop_e - size) : COORD_W'(ca_e + hop_e);
        cross_sel = cross_reg[axis_reg];
        nl_c      = (hop_reg[1] ? NL_W'({cross_sel, 1'b0}) : NL_W'(0))
                  + (hop_reg[0] ? NL_W'(cross_sel) : NL_W'(0));
        term_c[0] = IDX_W'(c_reg[0]);
        term_c[1] = IDX_W'(IDX_W'(ext_reg[0]) * IDX_W'(c_reg[1]));
        term_c[2] = IDX_W'(IDX_W'(p01_reg) * IDX_W'(c_reg[2]));
        term_c[3] = IDX_W'(IDX_W'(cross_reg[3]) * IDX_W'(c_reg[3]));
    end

    // lexicographic sum without the hop axis, and the neighbor axis terms
    idx_t base_c;
    idx_t stride_c;
    idx_t m_c [2];

    always_comb
    begin
        base_c = '0;
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            if (2'(i) != axis_reg)
                base_c = base_c + term_reg[i];
        end
        case (axis_reg)
            2'd0:    stride_c = IDX_W'(1);
            2'd1:    stride_c = IDX_W'(ext_reg[0]);
            2'd2:    stride_c = IDX_W'(p01_reg);
            default: stride_c = IDX_W'(cross_reg[3]);
        endcase
        m_c[0] = IDX_W'(stride_c * IDX_W'(nei_reg[0]));
        m_c[1] = IDX_W'(stride_c * IDX_W'(nei_reg[1]));
    end

    // slot counter read-modify-write; direction 0 in S_SUM, direction 1 in S_IDX
    logic [CNT_AW-1:0] ci [2];
    logic [CNT_AW-1:0] cnt_raddr;
    logic [CNT_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0]  rd_local;
    logic [CNT_W-1:0]  rd_halo;
    logic              dsel;
    logic              halo_cur;
    logic              rmw_active;
    logic [CNT_W-1:0]  cnt_old;
    logic [CNT_W-1:0]  cnt_next;
    vol_t              limit;
    logic              ovf_next;
    logic              we_local;
    logic              we_halo;

    always_comb
    begin
        ci[0]      = CNT_AW'({hop_reg - 2'd1, axis_reg, 1'b0});
        ci[1]      = CNT_AW'({hop_reg - 2'd1, axis_reg, 1'b1});
        cnt_raddr  = (state_reg == S_SUM) ? ci[1] : ci[0];
        dsel       = (state_reg == S_IDX);
        rmw_active = (state_reg == S_SUM) || (state_reg == S_IDX);
        cnt_waddr  = ci[dsel];
        halo_cur   = halo_reg[dsel];
        if (halo_cur)
        begin
            cnt_old = hvalid_reg[cnt_waddr] ? rd_halo : '0;
            limit   = VOL_W'(nl_reg);
        end
        else
        begin
            cnt_old = lvalid_reg[cnt_waddr] ? rd_local : '0;
            limit   = l_reg;
        end
        cnt_next = (cnt_old == CNT_MAX) ? CNT_MAX : cnt_old + CNT_W'(1);
        ovf_next = (VOL_W'(cnt_next) > limit) || (cnt_old == CNT_MAX);
        we_local = rmw_active && !halo_cur;
        we_halo  = rmw_active && halo_cur;
    end

    lhntg_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_local_cnt (
        .clk   (clk),
        .we    (we_local),
        .waddr (cnt_waddr),
        .wdata (cnt_next),
        .raddr (cnt_raddr),
        .rdata (rd_local)
    );

    lhntg_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_halo_cnt (
        .clk   (clk),
        .we    (we_halo),
        .waddr (cnt_waddr),
        .wdata (cnt_next),
        .raddr (cnt_raddr),
        .rdata (rd_halo)
    );

    // site ordering
    logic par_self;
    logic par_nei [2];

    always_comb
    begin
        par_self   = c_reg[0][0] ^ c_reg[1][0] ^ c_reg[2][0] ^ c_reg[3][0];
        par_nei[0] = par_self ^ ca[0] ^ nei_reg[0][0];
        par_nei[1] = par_self ^ ca[0] ^ nei_reg[1][0];
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                c_reg[i] <= (EXT_W'(in_coord[i]) >= ext_reg[i]) ?
                            COORD_W'(ext_reg[i] - EXT_W'(1)) : in_coord[i];
            end
            axis_reg <= in_axis;
            hop_reg  <= hop_next;
        end
        if (state_reg == S_MUL)
        begin
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                term_reg[i] <= term_c[i];
            end
            halo_reg[0] <= halo_c[0];
            halo_reg[1] <= halo_c[1];
            nei_reg[0]  <= nei_c[0];
            nei_reg[1]  <= nei_c[1];
            nl_reg      <= nl_c;
            l_reg       <= vol_reg - VOL_W'(nl_c);
        end
        if (state_reg == S_SUM)
        begin
            base_reg    <= base_c;
            m_reg[0]    <= m_c[0];
            m_reg[1]    <= m_c[1];
            slot_reg[0] <= cnt_old;
            ovf_reg[0]  <= ovf_next;
        end
        if (state_reg == S_IDX)
        begin
            lex_reg     <= base_reg + term_reg[axis_reg];
            lexn_reg[0] <= base_reg + m_reg[0];
            lexn_reg[1] <= base_reg + m_reg[1];
            slot_reg[1] <= cnt_old;
            ovf_reg[1]  <= ovf_next;
        end
        if (state_reg == S_ORD)
        begin
            self_reg    <= order_index(lex_reg, par_self, vol_reg, order_mode_reg);
            dest_reg[0] <= order_index(lexn_reg[0], par_nei[0], vol_reg, order_mode_reg);
            dest_reg[1] <= order_index(lexn_reg[1], par_nei[1], vol_reg, order_mode_reg);
        end
    end

    // result entries
    logic [79:0] entry_data [2];
    logic [3:0]  entry_user [2];

    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            entry_data[d] = {7'd0, ovf_reg[d], dest_reg[d],
                             halo_reg[d] ? slot_reg[d] : self_reg, slot_reg[d]};
            entry_user[d] = {halo_reg[d], axis_reg, 1'(d)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && (state_reg == S_OUT0))
        begin
            out_data_reg <= entry_data[0];
            out_user_reg <= entry_user[0];
            out_last_reg <= 1'b0;
        end
        else if (out_free && (state_reg == S_OUT1))
        begin
            out_data_reg <= entry_data[1];
            out_user_reg <= entry_user[1];
            out_last_reg <= 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            lvalid_reg    <= '0;
            hvalid_reg    <= '0;
        end
        else
        begin
            if (out_free && ((state_reg == S_OUT0) || (state_reg == S_OUT1)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (we_local)
            begin
                lvalid_reg[cnt_waddr] <= 1'b1;
            end
            if (we_halo)
            begin
                hvalid_reg[cnt_waddr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_clear)
                        begin
                            lvalid_reg <= '0;
                            hvalid_reg <= '0;
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_SUM;
                S_SUM: state_reg <= S_IDX;
                S_IDX: state_reg <= S_ORD;
                S_ORD: state_reg <= S_OUT0;
                S_OUT0:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_OUT1;
                    end
                end
                S_OUT1:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> src/lhntg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module lhntg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> tb/sv/lattice_hop_neighbor_table_gen_top_tb.sv
// Self-checking testbench for lattice_hop_neighbor_table_gen_top.
// Predicts both table entries of every request and compares them with the output stream.
// Depends on lhntg_pkg and the top level RTL only.
`timescale 1ns / 100ps

module lattice_hop_neighbor_table_gen_top_tb
    import lhntg_pkg::*;
();

    localparam int MAX_HOP        = 3;
    localparam int NUM_CNT        = MAX_HOP * 2 * NUM_DIMS;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_T = 2'd3;

    // request layout, lowest bits first: x, y, z, t, axis, hop_len, clear
    typedef struct packed {
        logic                             clear;
        logic [1:0]                       hop_len;
        logic [1:0]                       axis;
        logic [NUM_DIMS-1:0][COORD_W-1:0] coord;
    } hop_req_t;

    typedef struct packed {
        logic [2:0] direction;
        logic       is_halo;
        idx_t       slot;
        idx_t       src_index;
        idx_t       dest_index;
        logic       overflow;
        logic       last;
    } table_entry_t;

    typedef struct packed {
        logic [6:0] fill;
        logic       overflow;
        idx_t       dest_index;
        idx_t       src_index;
        idx_t       slot;
    } entry_data_t;

    class hop_table_scoreboard;
        ext_t         ext_reg[NUM_DIMS];
        logic         order_mode;
        int unsigned  local_cnt[NUM_CNT];
        int unsigned  halo_cnt[NUM_CNT];
        table_entry_t pending[$];
        int unsigned  requests;
        int unsigned  entries;
        int unsigned  errors;

        function new();
            int i;
            for (i = 0; i < NUM_DIMS; i++)
                ext_reg[i] = EXT_W'(EXT_MIN);
            order_mode = 1'b0;
            for (i = 0; i < NUM_CNT; i++)
            begin
                local_cnt[i] = 0;
                halo_cnt[i]  = 0;
            end
            requests = 0;
            entries  = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, ext_t val);
            case (idx) inside
                REG_EXTENT_X, REG_EXTENT_Y, REG_EXTENT_Z, REG_EXTENT_T:
                    ext_reg[idx] = val;
                REG_ORDER_MODE:
                    order_mode = val[0];
                default:
                    ;
            endcase
        endfunction

        function int unsigned eff_extent(int i);
            if (ext_reg[i] < EXT_MIN)
                return EXT_MIN;
            if (ext_reg[i] > MAX_EXTENT)
                return MAX_EXTENT;
            return ext_reg[i];
        endfunction

        function int unsigned ordered_site(int unsigned c[NUM_DIMS], int unsigned e[NUM_DIMS],
                                           int unsigned vol);
            int unsigned lex;
            lex = c[0] + e[0] * (c[1] + e[1] * (c[2] + e[2] * c[3]));
            // checkerboard: even-parity sites go to the upper half
            if (order_mode)
                lex = ((c[0] + c[1] + c[2] + c[3]) % 2 == 0) ? lex / 2 + vol / 2 : lex / 2;
            return lex & ((1 << IDX_W) - 1);
        endfunction

        function void note_request(hop_req_t r);
            int unsigned e[NUM_DIMS];
            int unsigned c[NUM_DIMS];
            int unsigned nb[NUM_DIMS];
            int unsigned vol, hop, ax, span, halo_lim, local_lim, self_idx;
            int unsigned cidx, old_cnt, new_cnt, lim;
            bit           wraps;
            table_entry_t x;
            int           i, d;
            vol = 1;
            for (i = 0; i < NUM_DIMS; i++)
            begin
                e[i] = eff_extent(i);
                vol *= e[i];
                c[i] = r.coord[i];
                if (c[i] >= e[i])
                    c[i] = e[i] - 1;
            end
            ax  = r.axis;
            hop = (r.hop_len == 0) ? 1 : r.hop_len;
            if (hop > MAX_HOP)
                hop = MAX_HOP;
            if (r.clear)
            begin
                for (i = 0; i < NUM_CNT; i++)
                begin
                    local_cnt[i] = 0;
                    halo_cnt[i]  = 0;
                end
            end
            span      = e[ax];
            halo_lim  = hop * (vol / span);
            local_lim = vol - halo_lim;
            self_idx  = ordered_site(c, e, vol);
            for (d = 0; d < 2; d++)
            begin
                nb = c;
                if (d == 0)
                begin
                    wraps  = c[ax] < hop;
                    nb[ax] = wraps ? span - hop + c[ax] : c[ax] - hop;
                end
                else
                begin
                    wraps  = c[ax] >= span - hop;
                    nb[ax] = wraps ? c[ax] + hop - span : c[ax] + hop;
                end
                cidx    = (hop - 1) * 2 * NUM_DIMS + 2 * ax + d;
                old_cnt = wraps ? halo_cnt[cidx] : local_cnt[cidx];
                new_cnt = (old_cnt < CNT_MAX) ? old_cnt + 1 : old_cnt;
                lim     = wraps ? halo_lim : local_lim;
                if (wraps)
                    halo_cnt[cidx] = new_cnt;
                else
                    local_cnt[cidx] = new_cnt;
                x.direction  = 3'(2 * ax + d);
                x.is_halo    = wraps;
                x.slot       = idx_t'(old_cnt);
                x.src_index  = wraps ? idx_t'(old_cnt) : idx_t'(self_idx);
                x.dest_index = idx_t'(ordered_site(nb, e, vol));
                x.overflow   = (new_cnt > lim) || (old_cnt == CNT_MAX);
                x.last       = (d == 1);
                pending.push_back(x);
            end
            requests++;
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, seen);
                errors++;
            end
        endfunction

        function void check_entry(table_entry_t seen);
            table_entry_t want;
            entries++;
            if (pending.size() == 0)
            begin
                $error("table entry with no request pending: dir %0d slot %0d",
                       seen.direction, seen.slot);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("direction", want.direction, seen.direction);
            compare_field("is_halo", want.is_halo, seen.is_halo);
            compare_field("slot", want.slot, seen.slot);
            compare_field("src_index", want.src_index, seen.src_index);
            compare_field("dest_index", want.dest_index, seen.dest_index);
            compare_field("overflow", want.overflow, seen.overflow);
            compare_field("last", want.last, seen.last);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [EXT_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [79:0]          m_axis_tdata;
    logic [3:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    entry_data_t result_data;
    assign result_data = m_axis_tdata;

    hop_table_scoreboard sb = new();
    bit          quiet        = 1'b0;
    bit          hold_output  = 1'b0;
    int unsigned settings     = 1;
    int unsigned stall_cycles = 0;

    lattice_hop_neighbor_table_gen_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic hop_req_t pack_req(coord_t x, coord_t y, coord_t z, coord_t t,
                                          logic [1:0] axis, logic [1:0] hop, logic clear);
        hop_req_t r;
        r.coord   = {t, z, y, x};
        r.axis    = axis;
        r.hop_len = hop;
        r.clear   = clear;
        return r;
    endfunction

    function automatic hop_req_t random_request();
        hop_req_t    r;
        int unsigned span;
        int          i;
        r.axis    = 2'($urandom_range(0, 3));
        r.hop_len = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        r.clear   = ($urandom_range(0, 19) == 0);
        for (i = 0; i < NUM_DIMS; i++)
        begin
            span = sb.eff_extent(i);
            if ($urandom_range(0, 9) == 0)
                r.coord[i] = COORD_W'($urandom_range(0, 63));
            else if (i == r.axis && $urandom_range(0, 1) == 1)
                // near either face so that wraps are frequent
                r.coord[i] = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 2)
                                                            : span - 1 - $urandom_range(0, 2));
            else
                r.coord[i] = COORD_W'($urandom_range(0, span - 1));
        end
        return r;
    endfunction

    task automatic send_request(input hop_req_t r);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 32'(r);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic random_run(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_request(random_request());
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input ext_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_geometry(input ext_t ex, input ext_t ey, input ext_t ez, input ext_t et,
                                input logic mode);
        write_reg(REG_EXTENT_X, ex);
        write_reg(REG_EXTENT_Y, ey);
        write_reg(REG_EXTENT_Z, ez);
        write_reg(REG_EXTENT_T, et);
        write_reg(REG_ORDER_MODE, {6'($urandom), mode});
        // index past the register map, must be dropped
        write_reg(CFG_IDX_W'($urandom_range(REG_ORDER_MODE + 1, (1 << CFG_IDX_W) - 1)),
                  EXT_W'($urandom));
        cfg_we <= 1'b0;
        settings++;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_entry({m_axis_tuser[2:0], m_axis_tuser[3], result_data.slot,
                            result_data.src_index, result_data.dest_index,
                            result_data.overflow, m_axis_tlast});
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we
            || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lattice_hop_neighbor_table_gen_top_tb NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 4^4 lexicographic
        send_request(pack_req(0, 0, 0, 0, AXIS_X, 1, 0));
        send_request(pack_req(0, 0, 0, 0, AXIS_Y, 1, 0));
        send_request(pack_req(0, 0, 0, 0, AXIS_Z, 2, 0));
        send_request(pack_req(0, 0, 0, 0, AXIS_T, 3, 0));
        send_request(pack_req(3, 3, 3, 3, AXIS_X, 3, 0));
        send_request(pack_req(3, 3, 3, 3, AXIS_Y, 2, 0));
        send_request(pack_req(3, 3, 3, 3, AXIS_Z, 1, 0));
        send_request(pack_req(3, 3, 3, 3, AXIS_T, 3, 0));
        send_request(pack_req(1, 2, 1, 2, AXIS_X, 0, 0));      // zero hop
        send_request(pack_req(63, 63, 63, 63, AXIS_Y, 2, 0));  // coordinates past extent
        send_request(pack_req(4, 5, 6, 7, AXIS_Z, 1, 0));
        send_request(pack_req(2, 1, 3, 0, AXIS_T, 2, 1));
        send_request(pack_req(1, 1, 1, 1, AXIS_X, 3, 0));
        wait_drained();

        set_geometry(64, 64, 64, 64, 1'b1);
        send_request(pack_req(0, 0, 0, 0, AXIS_X, 3, 0));
        send_request(pack_req(63, 63, 63, 63, AXIS_T, 3, 0));
        send_request(pack_req(63, 0, 63, 0, AXIS_Y, 1, 0));
        send_request(pack_req(62, 63, 1, 0, AXIS_Z, 2, 0));
        send_request(pack_req(32, 31, 5, 60, AXIS_X, 1, 1));
        send_request(pack_req(1, 0, 0, 0, AXIS_X, 0, 0));
        random_run(30);
        hold_output = 1'b1;
        random_run(25);
        wait_drained();
        random_run(25);
        wait_drained();

        // small lattice, same counter hit repeatedly until both tables overflow
        set_geometry(4, 4, 4, 4, 1'b0);
        for (k = 0; k < 70; k++)
            send_request(pack_req(3, COORD_W'($urandom_range(0, 3)),
                                  COORD_W'($urandom_range(0, 3)),
                                  COORD_W'($urandom_range(0, 3)), AXIS_X, 3, k == 0));
        for (k = 0; k < 70; k++)
            send_request(pack_req(0, COORD_W'($urandom_range(0, 3)),
                                  COORD_W'($urandom_range(0, 3)),
                                  COORD_W'($urandom_range(0, 3)), AXIS_X, 1, 0));
        wait_drained();

        set_geometry(3, 65, 0, 127, 1'b1);
        random_run(60);
        wait_drained();

        set_geometry(5, 7, 9, 13, 1'b1);
        random_run(80);
        wait_drained();

        set_geometry(EXT_W'($urandom_range(4, 64)), EXT_W'($urandom_range(4, 64)),
                     EXT_W'($urandom_range(4, 64)), EXT_W'($urandom_range(4, 64)),
                     1'($urandom_range(0, 1)));
        random_run(80);
        wait_drained();

        quiet = 1'b1;
        set_geometry(EXT_W'($urandom_range(0, 127)), EXT_W'($urandom_range(0, 127)),
                     EXT_W'($urandom_range(0, 127)), EXT_W'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)));
        random_run(60);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d table entries checked, %0d register settings",
                 sb.requests, sb.entries, settings);
        if (sb.errors == 0)
            $display("lattice_hop_neighbor_table_gen_top_tb OK");
        else
            $display("lattice_hop_neighbor_table_gen_top_tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
src/lhntg_pkg.sv
src/lhntg_ram.sv
src/lattice_hop_neighbor_table_gen_top.sv
tb/sv/lattice_hop_neighbor_table_gen_top_tb.sv
